### rtl/fnop_pkg.sv
`default_nettype none
package fnop_pkg;

    // Field separator and the characters the parser reacts to.
    localparam logic [7:0] CHAR_SEP   = 8'h01;
    localparam logic [7:0] CHAR_EQUAL = 8'h3D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_ONE   = 8'h31;

    // Parser phases.
    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_TAG   = 2'd1;
    localparam logic [1:0] PHASE_VALUE = 2'd2;

    // Message type tracking for tag 35.
    localparam logic [1:0] TYPE_ABSENT    = 2'd0;
    localparam logic [1:0] TYPE_OTHER     = 2'd1;
    localparam logic [1:0] TYPE_NEW_ORDER = 2'd2;

    // Tags of interest (all below 100, so seven bits hold them).
    localparam logic [6:0] TAG_TRAILER  = 7'd10;
    localparam logic [6:0] TAG_MSG_TYPE = 7'd35;
    localparam logic [6:0] TAG_ORDER_ID = 7'd11;
    localparam logic [6:0] TAG_SIDE     = 7'd54;
    localparam logic [6:0] TAG_PRICE    = 7'd44;
    localparam logic [6:0] TAG_QTY      = 7'd38;
    localparam logic [6:0] TAG_ORD_TYPE = 7'd40;
    localparam logic [6:0] TAG_MAX      = 7'd99;

    // Overflow mark bits.
    localparam int MARK_ID    = 0;
    localparam int MARK_PRICE = 1;
    localparam int MARK_QTY   = 2;

    // Queue between the byte classifier and the parsing engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One stream byte after classification.
    typedef struct packed {
        logic       is_sep;
        logic       is_equal;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_char_d;
        logic       is_char_one;
    } byte_class_t;

    // One-hot first-occurrence slot of a tag, zero when the tag is not tracked.
    function automatic logic [5:0] tag_slot(input logic [6:0] tag);
        logic [5:0] slot;
        begin
            case (tag)
                TAG_MSG_TYPE: slot = 6'b000001;
                TAG_ORDER_ID: slot = 6'b000010;
                TAG_SIDE:     slot = 6'b000100;
                TAG_PRICE:    slot = 6'b001000;
                TAG_QTY:      slot = 6'b010000;
                TAG_ORD_TYPE: slot = 6'b100000;
                default:      slot = 6'b000000;
            endcase
            return slot;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/fnop_front.sv
`default_nettype none
module fnop_front
    import fnop_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             push_valid,
    input  wire logic        push_ready,
    output byte_class_t      push_item
);

    logic        valid_reg;
    byte_class_t item_reg;
    byte_class_t item_next;
    logic [3:0]  digit_full;

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;
    assign digit_full = in_byte[3:0] - CHAR_ZERO[3:0];

    always_comb begin
        item_next.is_sep      = (in_byte == CHAR_SEP);
        item_next.is_equal    = (in_byte == CHAR_EQUAL);
        item_next.is_digit    = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
        item_next.digit       = digit_full;
        item_next.is_char_d   = (in_byte == CHAR_D);
        item_next.is_char_one = (in_byte == CHAR_ONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (push_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

### rtl/fnop_queue.sv
`default_nettype none
module fnop_queue
    import fnop_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         wr_valid,
    output logic              wr_ready,
    input  wire byte_class_t  wr_item,
    output logic              rd_valid,
    input  wire logic         rd_ready,
    output byte_class_t       rd_item
);

    byte_class_t           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign wr_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (!do_wr && do_rd) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

### rtl/fnop_back.sv
`default_nettype none
module fnop_back
    import fnop_pkg::*;
#(
    parameter int ID_WIDTH     = 64,
    parameter int PRICE_WIDTH  = 32,
    parameter int QTY_WIDTH    = 32,
    parameter int LENGTH_WIDTH = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    item_valid,
    output logic                         item_ready,
    input  wire byte_class_t             item,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output logic [ID_WIDTH-1:0]          res_order_id,
    output logic                         res_is_sell,
    output logic [PRICE_WIDTH-1:0]       res_limit_price,
    output logic [QTY_WIDTH-1:0]         res_order_quantity,
    output logic                         res_is_limit,
    output logic                         res_number_overflow,
    output logic [LENGTH_WIDTH-1:0]      res_message_bytes
);

    logic [1:0]              phase_reg, phase_next;
    logic [6:0]              tag_reg, tag_next;
    logic                    tag_bad_reg, tag_bad_next;
    logic [5:0]              seen_reg, seen_next;
    logic [1:0]              type_reg, type_next;
    logic [1:0]              vlen_reg, vlen_next;
    logic                    first_d_reg, first_d_next;
    logic                    first_one_reg, first_one_next;
    logic                    digits_done_reg, digits_done_next;
    logic                    sell_reg, sell_next;
    logic                    limit_reg, limit_next;
    logic [ID_WIDTH-1:0]     id_acc_reg, id_acc_next;
    logic [PRICE_WIDTH-1:0]  price_acc_reg, price_acc_next;
    logic [QTY_WIDTH-1:0]    qty_acc_reg, qty_acc_next;
    logic [2:0]              ovf_reg, ovf_next;
    logic [LENGTH_WIDTH-1:0] count_reg, count_next;
    logic                    trailer_reg, trailer_next;

    logic                    out_valid_reg;
    logic                    pop;
    logic                    emit;
    logic [LENGTH_WIDTH-1:0] count_inc;
    logic [9:0]              tag_prod;
    logic [ID_WIDTH+3:0]     id_prod;
    logic [PRICE_WIDTH+3:0]  price_prod;
    logic [QTY_WIDTH+3:0]    qty_prod;
    logic [5:0]              slot;
    logic                    value_one;

    // A separator may end a message, so it waits while an unread result is held.
    assign item_ready = !out_valid_reg || res_ready || !item.is_sep;
    assign pop        = item_valid && item_ready;
    assign res_valid  = out_valid_reg;

    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    // Next values of each accumulator and of the tag, times ten plus the digit.
    assign tag_prod   = ({3'b000, tag_reg} << 3) + ({3'b000, tag_reg} << 1)
                        + {6'b000000, item.digit};
    assign id_prod    = ({4'b0000, id_acc_reg} << 3) + ({4'b0000, id_acc_reg} << 1)
                        + (ID_WIDTH+4)'(item.digit);
    assign price_prod = ({4'b0000, price_acc_reg} << 3) + ({4'b0000, price_acc_reg} << 1)
                        + (PRICE_WIDTH+4)'(item.digit);
    assign qty_prod   = ({4'b0000, qty_acc_reg} << 3) + ({4'b0000, qty_acc_reg} << 1)
                        + (QTY_WIDTH+4)'(item.digit);
    assign slot       = tag_slot(tag_reg);
    assign value_one  = (vlen_reg == 2'd1);

    assign emit = pop && (phase_reg == PHASE_VALUE) && item.is_sep && trailer_reg
                  && (type_reg == TYPE_NEW_ORDER);

    always_comb begin
        phase_next       = phase_reg;
        tag_next         = tag_reg;
        tag_bad_next     = tag_bad_reg;
        seen_next        = seen_reg;
        type_next        = type_reg;
        vlen_next        = vlen_reg;
        first_d_next     = first_d_reg;
        first_one_next   = first_one_reg;
        digits_done_next = digits_done_reg;
        sell_next        = sell_reg;
        limit_next       = limit_reg;
        id_acc_next      = id_acc_reg;
        price_acc_next   = price_acc_reg;
        qty_acc_next     = qty_acc_reg;
        ovf_next         = ovf_reg;
        count_next       = count_inc;
        trailer_next     = trailer_reg;

        case (phase_reg)
            PHASE_TAG: begin
                if (item.is_sep) begin
                    tag_next     = '0;
                    tag_bad_next = 1'b0;
                end else if (item.is_equal) begin
                    phase_next       = PHASE_VALUE;
                    vlen_next        = 2'd0;
                    first_d_next     = 1'b0;
                    first_one_next   = 1'b0;
                    digits_done_next = 1'b0;
                    if (!tag_bad_reg) begin
                        if (tag_reg == TAG_TRAILER) begin
                            trailer_next = 1'b1;
                            tag_bad_next = 1'b1;
                        end else if ((slot == 6'b000000) || ((seen_reg & slot) != 6'b000000)) begin
                            tag_bad_next = 1'b1;
                        end else begin
                            seen_next = seen_reg | slot;
                        end
                    end
                end else if (!tag_bad_reg) begin
                    // Canonical decimal only: no leading zero, at most two digits.
                    if (!item.is_digit || ((tag_reg == '0) && (item.digit == 4'd0))) begin
                        tag_bad_next = 1'b1;
                    end else if (tag_prod > {3'b000, TAG_MAX}) begin
                        tag_next     = '0;
                        tag_bad_next = 1'b1;
                    end else begin
                        tag_next = tag_prod[6:0];
                    end
                end
            end
            PHASE_VALUE: begin
                if (!item.is_sep) begin
                    if (!tag_bad_reg) begin
                        if (vlen_reg == 2'd0) begin
                            first_d_next   = item.is_char_d;
                            first_one_next = item.is_char_one;
                        end
                        if (vlen_reg != 2'd2) begin
                            vlen_next = vlen_reg + 1'b1;
                        end
                        if ((tag_reg == TAG_ORDER_ID) || (tag_reg == TAG_PRICE)
                                || (tag_reg == TAG_QTY)) begin
                            if (!digits_done_reg) begin
                                if (!item.is_digit) begin
                                    digits_done_next = 1'b1;
                                end else if (tag_reg == TAG_ORDER_ID) begin
                                    if (!ovf_reg[MARK_ID]) begin
                                        if (id_prod[ID_WIDTH+3:ID_WIDTH] != 4'b0000) begin
                                            ovf_next[MARK_ID] = 1'b1;
                                            id_acc_next       = '0;
                                        end else begin
                                            id_acc_next = id_prod[ID_WIDTH-1:0];
                                        end
                                    end
                                end else if (tag_reg == TAG_PRICE) begin
                                    if (!ovf_reg[MARK_PRICE]) begin
                                        if (price_prod[PRICE_WIDTH+3:PRICE_WIDTH] != 4'b0000) begin
                                            ovf_next[MARK_PRICE] = 1'b1;
                                            price_acc_next       = '0;
                                        end else begin
                                            price_acc_next = price_prod[PRICE_WIDTH-1:0];
                                        end
                                    end
                                end else begin
                                    if (!ovf_reg[MARK_QTY]) begin
                                        if (qty_prod[QTY_WIDTH+3:QTY_WIDTH] != 4'b0000) begin
                                            ovf_next[MARK_QTY] = 1'b1;
                                            qty_acc_next       = '0;
                                        end else begin
                                            qty_acc_next = qty_prod[QTY_WIDTH-1:0];
                                        end
                                    end
                                end
                            end
                        end
                    end
                end else begin
                    if (!tag_bad_reg) begin
                        if (tag_reg == TAG_MSG_TYPE) begin
                            type_next = (value_one && first_d_reg) ? TYPE_NEW_ORDER : TYPE_OTHER;
                        end else if (tag_reg == TAG_SIDE) begin
                            sell_next = !(value_one && first_one_reg);
                        end else if (tag_reg == TAG_ORD_TYPE) begin
                            limit_next = !(value_one && first_one_reg);
                        end
                    end
                    if (!trailer_reg) begin
                        phase_next   = PHASE_TAG;
                        tag_next     = '0;
                        tag_bad_next = 1'b0;
                    end else begin
                        // End of message: back to the cleared state.
                        phase_next       = PHASE_FIRST;
                        tag_next         = '0;
                        tag_bad_next     = 1'b0;
                        seen_next        = '0;
                        type_next        = TYPE_ABSENT;
                        vlen_next        = 2'd0;
                        first_d_next     = 1'b0;
                        first_one_next   = 1'b0;
                        digits_done_next = 1'b0;
                        sell_next        = 1'b1;
                        limit_next       = 1'b1;
                        id_acc_next      = '0;
                        price_acc_next   = '0;
                        qty_acc_next     = '0;
                        ovf_next         = '0;
                        count_next       = '0;
                        trailer_next     = 1'b0;
                    end
                end
            end
            default: begin
                if (item.is_sep) begin
                    phase_next   = PHASE_TAG;
                    tag_next     = '0;
                    tag_bad_next = 1'b0;
                end else begin
                    phase_next = PHASE_FIRST;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PHASE_FIRST;
            tag_reg         <= '0;
            tag_bad_reg     <= 1'b0;
            seen_reg        <= '0;
            type_reg        <= TYPE_ABSENT;
            vlen_reg        <= 2'd0;
            first_d_reg     <= 1'b0;
            first_one_reg   <= 1'b0;
            digits_done_reg <= 1'b0;
            sell_reg        <= 1'b1;
            limit_reg       <= 1'b1;
            id_acc_reg      <= '0;
            price_acc_reg   <= '0;
            qty_acc_reg     <= '0;
            ovf_reg         <= '0;
            count_reg       <= '0;
            trailer_reg     <= 1'b0;
        end else if (pop) begin
            phase_reg       <= phase_next;
            tag_reg         <= tag_next;
            tag_bad_reg     <= tag_bad_next;
            seen_reg        <= seen_next;
            type_reg        <= type_next;
            vlen_reg        <= vlen_next;
            first_d_reg     <= first_d_next;
            first_one_reg   <= first_one_next;
            digits_done_reg <= digits_done_next;
            sell_reg        <= sell_next;
            limit_reg       <= limit_next;
            id_acc_reg      <= id_acc_next;
            price_acc_reg   <= price_acc_next;
            qty_acc_reg     <= qty_acc_next;
            ovf_reg         <= ovf_next;
            count_reg       <= count_next;
            trailer_reg     <= trailer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (res_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            res_order_id        <= id_acc_reg;
            res_is_sell         <= sell_reg;
            res_limit_price     <= price_acc_reg;
            res_order_quantity  <= qty_acc_reg;
            res_is_limit        <= limit_reg;
            res_number_overflow <= (ovf_reg != 3'b000);
            res_message_bytes   <= count_inc;
        end
    end

endmodule
`default_nettype wire

### rtl/fix_new_order_field_parser_top.sv
`default_nettype none
// New-order field parser. Bytes of a tag=value stream (SOH separated) enter on the
// s_ channel, one byte per transfer and up to one transfer per cycle. A message
// ends at the separator after its first tag 10 field; if its tag 35 value is
// exactly "D", one order result leaves on the m_ channel, otherwise nothing. The
// parsing engine takes one byte per cycle while it is not halted, which sets the
// sustained rate. After the final separator is accepted, it passes through the
// classifier register and the queue, and the result is then registered in the
// engine's output register. While a result waits unread, the engine
// halts on the next separator and the four-entry queue and the classifier
// register absorb the bytes behind it before s_tready falls.
module fix_new_order_field_parser_top
    import fnop_pkg::*;
#(
    parameter int ID_WIDTH     = 64,
    parameter int PRICE_WIDTH  = 32,
    parameter int QTY_WIDTH    = 32,
    parameter int LENGTH_WIDTH = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // data_byte
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // order_id, is_sell, limit_price, order_quantity, is_limit, number_overflow,
    // message_bytes, then zero fill
    output logic [((ID_WIDTH+PRICE_WIDTH+QTY_WIDTH+LENGTH_WIDTH+3+7)/8)*8-1:0] m_tdata
);

    localparam int FIELD_BITS = ID_WIDTH + PRICE_WIDTH + QTY_WIDTH + LENGTH_WIDTH + 3;
    localparam int DATA_BITS  = ((FIELD_BITS + 7) / 8) * 8;

    logic                    push_valid;
    logic                    push_ready;
    byte_class_t             push_item;
    logic                    pop_valid;
    logic                    pop_ready;
    byte_class_t             pop_item;
    logic [ID_WIDTH-1:0]     order_id;
    logic                    is_sell;
    logic [PRICE_WIDTH-1:0]  limit_price;
    logic [QTY_WIDTH-1:0]    order_quantity;
    logic                    is_limit;
    logic                    number_overflow;
    logic [LENGTH_WIDTH-1:0] message_bytes;

    fnop_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    fnop_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_item  (pop_item)
    );

    fnop_back #(
        .ID_WIDTH     (ID_WIDTH),
        .PRICE_WIDTH  (PRICE_WIDTH),
        .QTY_WIDTH    (QTY_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .item_valid          (pop_valid),
        .item_ready          (pop_ready),
        .item                (pop_item),
        .res_valid           (m_tvalid),
        .res_ready           (m_tready),
        .res_order_id        (order_id),
        .res_is_sell         (is_sell),
        .res_limit_price     (limit_price),
        .res_order_quantity  (order_quantity),
        .res_is_limit        (is_limit),
        .res_number_overflow (number_overflow),
        .res_message_bytes   (message_bytes)
    );

    assign m_tdata = DATA_BITS'({message_bytes, number_overflow, is_limit, order_quantity,
                                 limit_price, is_sell, order_id});

endmodule
`default_nettype wire

### dv/fix_new_order_field_parser_top_tb.sv
`timescale 1ns / 100ps

module fix_new_order_field_parser_top_tb;
    import fnop_pkg::*;

    // Result layout on m_tdata, lowest field last.
    typedef struct packed {
        logic [4:0]  zero_fill;
        logic [15:0] message_bytes;
        logic        number_overflow;
        logic        is_limit;
        logic [31:0] order_quantity;
        logic [31:0] limit_price;
        logic        is_sell;
        logic [63:0] order_id;
    } order_t;

    typedef enum {CHECK_MODEL, CHECK_ORDER, CHECK_DROP} row_check_t;

    typedef struct {
        string      text;
        row_check_t mode;
        order_t     order;
    } script_row_t;

    localparam logic [7:0] SCRIPT_SEP  = 8'h7C;   // '|' stands for SOH in script text
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         HOLD_AT     = 3;
    localparam int         PAUSE_AT    = 16;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [7:0]    s_tdata  = 8'h00;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [$bits(order_t)-1:0] m_tdata;   // order_t fields, order_id in the lowest bits

    fix_new_order_field_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    order_t      orders_due[$];
    script_row_t script[$];
    logic [7:0]  msg_bytes[$];
    row_check_t  cur_mode = CHECK_MODEL;
    int          mismatches = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          hold_request = 1'b0;

    // Parser state mirrored from the block.
    logic [1:0]  phase;
    logic [15:0] tag_num;
    logic        tag_skip;
    logic [5:0]  tags_taken;
    logic [1:0]  msg_type;
    logic [1:0]  val_len;
    logic [7:0]  val_first;
    logic        digits_end;
    logic        sell_now;
    logic        limit_now;
    logic [63:0] id_acc;
    logic [63:0] price_acc;
    logic [63:0] qty_acc;
    logic [2:0]  ovf_marks;
    logic [15:0] byte_cnt;
    logic        trailer_hit;

    function automatic void clear_message();
        phase       = PHASE_FIRST;
        tag_num     = '0;
        tag_skip    = 1'b0;
        tags_taken  = '0;
        msg_type    = TYPE_ABSENT;
        val_len     = '0;
        val_first   = '0;
        digits_end  = 1'b0;
        sell_now    = 1'b1;
        limit_now   = 1'b1;
        id_acc      = '0;
        price_acc   = '0;
        qty_acc     = '0;
        ovf_marks   = '0;
        byte_cnt    = '0;
        trailer_hit = 1'b0;
    endfunction

    function automatic void begin_tag();
        phase    = PHASE_TAG;
        tag_num  = '0;
        tag_skip = 1'b0;
    endfunction

    function automatic int first_use_slot(logic [15:0] tag);
        case (tag)
            TAG_MSG_TYPE: return 0;
            TAG_ORDER_ID: return 1;
            TAG_SIDE:     return 2;
            TAG_PRICE:    return 3;
            TAG_QTY:      return 4;
            TAG_ORD_TYPE: return 5;
            default:      return -1;
        endcase
    endfunction

    function automatic void close_tag();
        int slot;
        phase      = PHASE_VALUE;
        val_len    = '0;
        val_first  = '0;
        digits_end = 1'b0;
        if (!tag_skip) begin
            if (tag_num == TAG_TRAILER) begin
                // The trailer's own value is never captured.
                trailer_hit = 1'b1;
                tag_skip    = 1'b1;
            end else begin
                slot = first_use_slot(tag_num);
                if (slot < 0 || tags_taken[slot])
                    tag_skip = 1'b1;
                else
                    tags_taken[slot] = 1'b1;
            end
        end
    endfunction

    function automatic void tag_char(logic [7:0] c);
        if (!tag_skip) begin
            if (c < CHAR_ZERO || c > CHAR_NINE || (tag_num == 0 && c == CHAR_ZERO)) begin
                tag_skip = 1'b1;
            end else begin
                tag_num = tag_num * 16'd10 + (c - CHAR_ZERO);
                if (tag_num > TAG_MAX) begin
                    tag_num  = '0;
                    tag_skip = 1'b1;
                end
            end
        end
    endfunction

    function automatic void add_digit(inout logic [63:0] acc, input logic [63:0] top,
                                      input int mark, input logic [7:0] c);
        logic [67:0] grown;
        if (!digits_end) begin
            if (c < CHAR_ZERO || c > CHAR_NINE) begin
                digits_end = 1'b1;
            end else if (!ovf_marks[mark]) begin
                grown = acc * 68'd10 + (c - CHAR_ZERO);
                if (grown > {4'b0, top}) begin
                    ovf_marks[mark] = 1'b1;
                    acc = '0;
                end else begin
                    acc = grown[63:0];
                end
            end
        end
    endfunction

    function automatic void value_char(logic [7:0] c);
        if (val_len == 0)
            val_first = c;
        if (val_len < 2)
            val_len++;
        case (tag_num)
            TAG_ORDER_ID: add_digit(id_acc, 64'hFFFF_FFFF_FFFF_FFFF, MARK_ID, c);
            TAG_PRICE:    add_digit(price_acc, 64'hFFFF_FFFF, MARK_PRICE, c);
            TAG_QTY:      add_digit(qty_acc, 64'hFFFF_FFFF, MARK_QTY, c);
            default: ;
        endcase
    endfunction

    function automatic void close_value();
        logic single;
        single = (val_len == 1);
        case (tag_num)
            TAG_MSG_TYPE: msg_type  = (single && val_first == CHAR_D) ? TYPE_NEW_ORDER : TYPE_OTHER;
            TAG_SIDE:     sell_now  = !(single && val_first == CHAR_ONE);
            TAG_ORD_TYPE: limit_now = !(single && val_first == CHAR_ONE);
            default: ;
        endcase
    endfunction

    // Advances the mirrored parser by one byte; returns 1 with the order when a
    // new-order message completes on this byte.
    function automatic bit parse_order_byte(input logic [7:0] c, output order_t ord);
        bit emitted;
        emitted = 1'b0;
        ord     = '0;
        if (byte_cnt != 16'hFFFF)
            byte_cnt++;
        case (phase)
            PHASE_TAG: begin
                if (c == CHAR_SEP)
                    begin_tag();
                else if (c == CHAR_EQUAL)
                    close_tag();
                else
                    tag_char(c);
            end
            PHASE_VALUE: begin
                if (c != CHAR_SEP) begin
                    if (!tag_skip)
                        value_char(c);
                end else begin
                    if (!tag_skip)
                        close_value();
                    if (!trailer_hit) begin
                        begin_tag();
                    end else begin
                        if (msg_type == TYPE_NEW_ORDER) begin
                            emitted             = 1'b1;
                            ord.order_id        = id_acc;
                            ord.is_sell         = sell_now;
                            ord.limit_price     = price_acc[31:0];
                            ord.order_quantity  = qty_acc[31:0];
                            ord.is_limit        = limit_now;
                            ord.number_overflow = |ovf_marks;
                            ord.message_bytes   = byte_cnt;
                        end
                        clear_message();
                    end
                end
            end
            default: begin
                if (c == CHAR_SEP)
                    begin_tag();
                else
                    phase = PHASE_FIRST;
            end
        endcase
        return emitted;
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_order(order_t got);
        order_t want;
        if (orders_due.size() == 0) begin
            $display("%0t: unexpected order, expected none, got %h", $time, got);
            mismatches++;
        end else begin
            want = orders_due.pop_front();
            compare_field("order_id", want.order_id, got.order_id);
            compare_field("is_sell", want.is_sell, got.is_sell);
            compare_field("limit_price", want.limit_price, got.limit_price);
            compare_field("order_quantity", want.order_quantity, got.order_quantity);
            compare_field("is_limit", want.is_limit, got.is_limit);
            compare_field("number_overflow", want.number_overflow, got.number_overflow);
            compare_field("message_bytes", want.message_bytes, got.message_bytes);
            compare_field("zero_fill", want.zero_fill, got.zero_fill);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_order(order_t'(m_tdata));
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("fix_new_order_field_parser_top regression: fail");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 20);
                @(posedge aclk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        order_t ord;
        while (!calm && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (parse_order_byte(b, ord) && cur_mode == CHECK_MODEL)
            orders_due.push_back(ord);
    endtask

    task automatic drain_orders();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (orders_due.size() != 0);
    endtask

    function automatic void add_row(string text, row_check_t mode, logic [63:0] id,
                                    logic sell, logic [31:0] price, logic [31:0] qty,
                                    logic limit, logic ovf);
        script_row_t row;
        row.text  = text;
        row.mode  = mode;
        row.order = '{zero_fill: '0, message_bytes: '0, number_overflow: ovf,
                      is_limit: limit, order_quantity: qty, limit_price: price,
                      is_sell: sell, order_id: id};
        script.push_back(row);
    endfunction

    function automatic void put_text(string t);
        for (int i = 0; i < t.len(); i++)
            msg_bytes.push_back((t[i] == SCRIPT_SEP) ? CHAR_SEP : t[i]);
    endfunction

    function automatic void put_digits(int n);
        repeat (n) msg_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void put_junk(int n);
        logic [7:0] b;
        repeat (n) begin
            do b = 8'($urandom_range(255)); while (b == CHAR_SEP);
            msg_bytes.push_back(b);
        end
    endfunction

    function automatic void put_noise_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            msg_bytes.push_back(CHAR_SEP);
        else if (r < 35)
            msg_bytes.push_back(CHAR_EQUAL);
        else if (r < 60)
            put_digits(1);
        else
            msg_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void put_number(int max_digits, string top, string over);
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            put_text(top);
        end else if (r < 18) begin
            put_text(over);
        end else begin
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(1, 3)) msg_bytes.push_back(CHAR_ZERO);
            put_digits($urandom_range(0, max_digits + 2));
        end
        if ($urandom_range(99) < 25)
            put_junk($urandom_range(1, 4));
    endfunction

    function automatic void put_flag_value();
        case ($urandom_range(4))
            0, 1: put_text("1");
            2:    put_text("2");
            3:    put_text("11");
            default: put_junk($urandom_range(0, 2));
        endcase
    endfunction

    function automatic void put_field();
        int r;
        int tag;
        r = $urandom_range(99);
        put_text("|");
        if (r < 8) begin
            // Malformed tag text: leading zero, letters, three digits, an empty tag, or no '='.
            case ($urandom_range(4))
                0: put_text("035=D");
                1: put_text("1a1=5");
                2: put_text("100=7");
                3: put_text("=3");
                default: put_text("11");
            endcase
            return;
        end
        if (r < 23)
            tag = $urandom_range(1, 99);
        else if (r < 35)
            tag = TAG_MSG_TYPE;
        else
            case ($urandom_range(4))
                0: tag = TAG_ORDER_ID;
                1: tag = TAG_SIDE;
                2: tag = TAG_PRICE;
                3: tag = TAG_QTY;
                default: tag = TAG_ORD_TYPE;
            endcase
        put_text($sformatf("%0d=", tag));
        case (tag)
            TAG_MSG_TYPE: begin
                if ($urandom_range(99) < 60)
                    put_text("D");
                else
                    case ($urandom_range(3))
                        0: put_text("8");
                        1: put_text("DD");
                        2: put_text("");
                        default: put_junk($urandom_range(1, 3));
                    endcase
            end
            TAG_ORDER_ID: put_number(20, "18446744073709551615", "18446744073709551616");
            TAG_PRICE, TAG_QTY: put_number(10, "4294967295", "4294967296");
            TAG_SIDE, TAG_ORD_TYPE: put_flag_value();
            default: put_junk($urandom_range(0, 8));
        endcase
    endfunction

    // Mostly complete messages; some noise bursts and some messages cut
    // before their trailer, which then run into the next one.
    function automatic void build_message();
        int kind;
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 30)) put_noise_byte();
            return;
        end
        case ($urandom_range(3))
            0: ;
            1: put_text("8=FIX.4.2");
            2: put_text("35=D");
            default: put_junk($urandom_range(1, 6));
        endcase
        if ($urandom_range(99) < 75)
            put_text("|35=D");
        repeat ($urandom_range(0, 8)) put_field();
        if (kind >= 18) begin
            put_text("|10=");
            put_digits($urandom_range(0, 3));
            put_text("|");
        end
    endfunction

    initial begin
        order_t typed;
        int     msg_index;
        int     plain_sent;

        clear_message();
        add_row("8=FIX|35=D|11=42|54=1|44=100|38=5|40=1|10=000|", CHECK_ORDER,
                64'd42, 1'b0, 32'd100, 32'd5, 1'b0, 1'b0);
        add_row("8=FIX|35=8|11=1|10=1|", CHECK_DROP, '0, 0, '0, '0, 0, 0);
        add_row("|35=D|11=18446744073709551615|44=4294967295|38=4294967295|10=|",
                CHECK_ORDER, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1'b1, 1'b0);
        add_row("x|35=D|11=18446744073709551616|10=1|", CHECK_ORDER,
                '0, 1'b1, '0, '0, 1'b1, 1'b1);
        add_row("x|35=D|44=4294967296|10=1|", CHECK_ORDER, '0, 1'b1, '0, '0, 1'b1, 1'b1);
        add_row("x|35=D|38=04294967296|10=1|", CHECK_ORDER, '0, 1'b1, '0, '0, 1'b1, 1'b1);
        add_row("35=D|11=7|10=0|", CHECK_DROP, '0, 0, '0, '0, 0, 0);
        add_row("x|035=D|35=D|10=1|", CHECK_ORDER, '0, 1'b1, '0, '0, 1'b1, 1'b0);
        add_row("x|35=D|11=5|11=9|54=2|54=1|40=1|40=2|10=1|", CHECK_ORDER,
                64'd5, 1'b1, '0, '0, 1'b0, 1'b0);
        add_row("x|35=D|44=12.5|38=7x9|11=abc|10=1|", CHECK_ORDER,
                '0, 1'b1, 32'd12, 32'd7, 1'b1, 1'b0);
        add_row("x|35=DD|10=1|", CHECK_DROP, '0, 0, '0, '0, 0, 0);
        add_row("x|35=|10=1|", CHECK_DROP, '0, 0, '0, '0, 0, 0);
        add_row("x|35=d|10=1|", CHECK_DROP, '0, 0, '0, '0, 0, 0);
        add_row("x|35=D|54=11|40=12|10=1|", CHECK_ORDER, '0, 1'b1, '0, '0, 1'b1, 1'b0);
        add_row("x|10|x=1|=5|100=1|35=D|11=12=3|10=1|", CHECK_ORDER,
                64'd12, 1'b1, '0, '0, 1'b1, 1'b0);
        add_row("x||35=D||11=|44=|10=1|", CHECK_ORDER, '0, 1'b1, '0, '0, 1'b1, 1'b0);
        add_row("x|35=8|54=1|10=5|", CHECK_DROP, '0, 0, '0, '0, 0, 0);
        add_row("x|35=D|54=1|40=1|11=99|38=0|44=0|10=1|", CHECK_MODEL, '0, 0, '0, '0, 0, 0);
        add_row("x|35=D|11=000123|44=00|38=9=9|10=1|", CHECK_MODEL, '0, 0, '0, '0, 0, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[r]) begin
            cur_mode = script[r].mode;
            for (int i = 0; i < script[r].text.len(); i++)
                send_byte((script[r].text[i] == SCRIPT_SEP) ? CHAR_SEP : script[r].text[i]);
            if (script[r].mode == CHECK_ORDER) begin
                typed = script[r].order;
                typed.message_bytes = 16'(script[r].text.len());
                orders_due.push_back(typed);
            end
        end
        drain_orders();

        cur_mode   = CHECK_MODEL;
        msg_index  = 0;
        plain_sent = 0;
        while (plain_sent < 900 || msg_index <= PAUSE_AT) begin
            msg_bytes.delete();
            build_message();
            calm = (msg_index >= 8 && msg_index < 14);
            if (msg_index == HOLD_AT)
                hold_request = 1'b1;
            if (msg_index == PAUSE_AT)
                drain_orders();
            foreach (msg_bytes[i])
                send_byte(msg_bytes[i]);
            plain_sent += msg_bytes.size();
            msg_index++;
        end
        calm = 1'b0;

        drain_orders();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("fix_new_order_field_parser_top regression: pass");
        else
            $display("fix_new_order_field_parser_top regression: fail");
        $finish;
    end

endmodule

### fix_new_order_field_parser_top.f
rtl/fnop_pkg.sv
rtl/fnop_front.sv
rtl/fnop_queue.sv
rtl/fnop_back.sv
rtl/fix_new_order_field_parser_top.sv
dv/fix_new_order_field_parser_top_tb.sv
